[sv/rpncalc_pkg.sv]
// Package for the RPN stack calculator: field widths, word kind and status codes,
// and the command and result types of the shared arithmetic unit.
// Depends on nothing; every other file of the block but rpncalc_ram imports it.
package rpncalc_pkg;

   localparam int DATA_W = 32;
   localparam int KIND_W = 3;
   localparam int INDEX_W = 10;
   localparam int STATUS_W = 3;
   localparam int DEPTH_OUT_W = 11;
   localparam int STACK_DEPTH_DEFAULT = 1024;
   localparam int DIV_CNT_W = $clog2(DATA_W);

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH = 3'd0,
      KIND_POP = 3'd1,
      KIND_PEEK_TOP = 3'd2,
      KIND_PEEK_BOTTOM = 3'd3,
      KIND_ADD = 3'd4,
      KIND_SUB = 3'd5,
      KIND_MUL = 3'd6,
      KIND_DIV = 3'd7
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK = 3'd0,
      STATUS_EMPTY = 3'd1,
      STATUS_FEW = 3'd2,
      STATUS_RANGE = 3'd3,
      STATUS_DIVZERO = 3'd4,
      STATUS_FULL = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      ALU_ADD = 2'd0,
      ALU_SUB = 2'd1,
      ALU_MUL = 2'd2,
      ALU_DIV = 2'd3
   } alu_op_type;

   typedef struct packed {
      logic start;
      alu_op_type op;
   } alu_cmd_type;

   typedef struct packed {
      logic done;
      logic [DATA_W-1:0] value;
   } alu_res_type;

   function automatic alu_op_type kind_to_alu_op(input kind_type kind);
      alu_op_type op;
      case (kind)
         KIND_SUB: op = ALU_SUB;
         KIND_MUL: op = ALU_MUL;
         KIND_DIV: op = ALU_DIV;
         default: op = ALU_ADD;
      endcase
      return op;
   endfunction

endpackage

[sv/rpncalc_req_if.sv]
// Request channel of the RPN stack calculator: valid, ready and one input word.
// Depends on rpncalc_pkg for the field widths.
interface rpncalc_req_if;
   import rpncalc_pkg::*;

   logic valid;
   logic ready;
   logic [KIND_W-1:0] kind;
   logic signed [DATA_W-1:0] value;
   logic [INDEX_W-1:0] index;

   modport source(output valid, output kind, output value, output index, input ready);
   modport sink(input valid, input kind, input value, input index, output ready);
endinterface

[sv/rpncalc_rsp_if.sv]
// Response channel of the RPN stack calculator: valid, ready and one result word.
// Depends on rpncalc_pkg for the field widths.
interface rpncalc_rsp_if;
   import rpncalc_pkg::*;

   logic valid;
   logic ready;
   logic signed [DATA_W-1:0] result;
   logic [STATUS_W-1:0] status;
   logic [DEPTH_OUT_W-1:0] depth;

   modport source(output valid, output result, output status, output depth, input ready);
   modport sink(input valid, input result, input status, input depth, output ready);
endinterface

[sv/rpn_stack_calculator_core.sv]
// Top level of the RPN stack calculator: sequencer, stack RAM and shared ALU.
// Depends on rpncalc_pkg, rpncalc_req_if, rpncalc_rsp_if, rpncalc_ram and rpncalc_alu.
//
// Each request word carries a kind (push, pop, peek from top or bottom, add,
// subtract, multiply, divide), a value and an index; each one yields exactly one
// response word with the result, a status code and the stack depth afterwards.
// The block works on one word at a time and is ready only while it has none.
// A push, or any word that fails its checks on the depth or the index, goes
// straight to the finish state; a pop or peek first waits for its RAM read; a
// binary kind reads its operands, then runs in the ALU unless it divides by zero.
// Binary kinds read both operands through the one read port of the stack RAM;
// divide runs one quotient bit per cycle in the ALU.
// The response sits in an output register, so a new word is taken while the
// previous response waits; a stalled receiver holds the response stable and,
// once the next word is done, holds the block until the register frees.
// Reset empties the stack at once; the RAM contents are not cleared, and only
// entries below the depth are ever read.
module rpn_stack_calculator_core #(
   parameter int STACK_DEPTH = rpncalc_pkg::STACK_DEPTH_DEFAULT
) (
   input logic clock,
   input logic reset,
   rpncalc_req_if.sink req_port,
   rpncalc_rsp_if.source rsp_port
);
   import rpncalc_pkg::*;

   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
   localparam int CMP_W = (DEPTH_W > INDEX_W) ? DEPTH_W : INDEX_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_WAIT,
      ST_RD_SECOND,
      ST_OPERANDS,
      ST_EXEC,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   kind_type kind_ff, kind_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [DATA_W-1:0] top_ff, top_in;
   logic [DATA_W-1:0] res_ff, res_in;
   status_type status_ff, status_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_result_ff, rsp_result_in;
   status_type rsp_status_ff, rsp_status_in;
   logic [DEPTH_OUT_W-1:0] rsp_depth_ff, rsp_depth_in;

   kind_type req_kind;
   logic depth_full;
   logic depth_few;
   logic index_bad;
   logic [DEPTH_W-1:0] depth_m1;
   logic [DEPTH_W-1:0] depth_m2;
   logic [CMP_W-1:0] peek_top_pos;

   logic wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic [ADDR_W-1:0] rd_addr;
   logic [DATA_W-1:0] rd_data;
   alu_cmd_type alu_cmd;
   alu_res_type alu_res;

   assign req_kind = kind_type'(req_port.kind);
   assign depth_full = depth_ff == DEPTH_W'(STACK_DEPTH);
   assign depth_few = depth_ff < DEPTH_W'(2);
   assign index_bad = CMP_W'(req_port.index) >= CMP_W'(depth_ff);
   assign depth_m1 = depth_ff - DEPTH_W'(1);
   assign depth_m2 = depth_ff - DEPTH_W'(2);
   assign peek_top_pos = CMP_W'(depth_m1) - CMP_W'(req_port.index);

   rpncalc_ram #(
      .WIDTH(DATA_W),
      .DEPTH(STACK_DEPTH)
   ) u_ram (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   rpncalc_alu u_alu (
      .clock(clock),
      .reset(reset),
      .cmd(alu_cmd),
      .opa(rd_data),
      .opb(top_ff),
      .res(alu_res)
   );

   always_comb begin
      state_in = state_ff;
      kind_in = kind_ff;
      depth_in = depth_ff;
      top_in = top_ff;
      res_in = res_ff;
      status_in = status_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_port.ready;
      rsp_result_in = rsp_result_ff;
      rsp_status_in = rsp_status_ff;
      rsp_depth_in = rsp_depth_ff;
      wr_en = 1'b0;
      wr_addr = depth_ff[ADDR_W-1:0];
      wr_data = req_port.value;
      rd_addr = depth_m1[ADDR_W-1:0];
      alu_cmd.start = 1'b0;
      alu_cmd.op = kind_to_alu_op(kind_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_port.valid) begin
               kind_in = req_kind;
               res_in = '0;
               status_in = STATUS_OK;
               state_in = ST_FINISH;
               unique case (req_kind) inside
                  KIND_PUSH: begin
                     if (depth_full) begin
                        status_in = STATUS_FULL;
                     end else begin
                        wr_en = 1'b1;
                        depth_in = depth_ff + DEPTH_W'(1);
                     end
                  end
                  KIND_POP: begin
                     if (depth_ff == '0) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        depth_in = depth_m1;
                        state_in = ST_RD_WAIT;
                     end
                  end
                  KIND_PEEK_TOP: begin
                     rd_addr = peek_top_pos[ADDR_W-1:0];
                     if (index_bad) begin
                        status_in = STATUS_RANGE;
                     end else begin
                        state_in = ST_RD_WAIT;
                     end
                  end
                  KIND_PEEK_BOTTOM: begin
                     rd_addr = ADDR_W'(req_port.index);
                     if (index_bad) begin
                        status_in = STATUS_RANGE;
                     end else begin
                        state_in = ST_RD_WAIT;
                     end
                  end
                  KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV: begin
                     if (depth_few) begin
                        status_in = STATUS_FEW;
                     end else begin
                        state_in = ST_RD_SECOND;
                     end
                  end
               endcase
            end
         end
         ST_RD_WAIT: begin
            res_in = rd_data;
            state_in = ST_FINISH;
         end
         ST_RD_SECOND: begin
            top_in = rd_data;
            rd_addr = depth_m2[ADDR_W-1:0];
            state_in = ST_OPERANDS;
         end
         ST_OPERANDS: begin
            if (kind_ff == KIND_DIV && top_ff == '0) begin
               status_in = STATUS_DIVZERO;
               depth_in = depth_m2;
               state_in = ST_FINISH;
            end else begin
               alu_cmd.start = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (alu_res.done) begin
               wr_en = 1'b1;
               wr_addr = depth_m2[ADDR_W-1:0];
               wr_data = alu_res.value;
               res_in = alu_res.value;
               depth_in = depth_m1;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_valid_in = 1'b1;
               rsp_result_in = res_ff;
               rsp_status_in = status_ff;
               rsp_depth_in = DEPTH_OUT_W'(depth_ff);
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         depth_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         depth_ff <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff <= kind_in;
      top_ff <= top_in;
      res_ff <= res_in;
      status_ff <= status_in;
      rsp_result_ff <= rsp_result_in;
      rsp_status_ff <= rsp_status_in;
      rsp_depth_ff <= rsp_depth_in;
   end

   assign req_port.ready = state_ff == ST_IDLE;
   assign rsp_port.valid = rsp_valid_ff;
   assign rsp_port.result = rsp_result_ff;
   assign rsp_port.status = rsp_status_ff;
   assign rsp_port.depth = rsp_depth_ff;
endmodule

[sv/rpncalc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; used for the stack storage.
module rpncalc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input logic clock,
   input logic wr_en,
   input logic [ADDR_W-1:0] wr_addr,
   input logic [WIDTH-1:0] wr_data,
   input logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[sv/rpncalc_alu.sv]
// Shared arithmetic unit of the RPN stack calculator: add, subtract and multiply
// with a registered result, floor division by a radix-2 restoring divider. Depends on rpncalc_pkg.
module rpncalc_alu (
   input logic clock,
   input logic reset,
   input rpncalc_pkg::alu_cmd_type cmd,
   input logic [rpncalc_pkg::DATA_W-1:0] opa,
   input logic [rpncalc_pkg::DATA_W-1:0] opb,
   output rpncalc_pkg::alu_res_type res
);
   import rpncalc_pkg::*;

   typedef enum logic [1:0] {
      A_IDLE,
      A_DIV,
      A_FIX
   } alu_state_type;

   alu_state_type state_ff, state_in;
   logic done_ff, done_in;
   logic [DATA_W-1:0] value_ff, value_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic neg_ff, neg_in;

   logic [DATA_W-1:0] mag_a;
   logic [DATA_W-1:0] mag_b;
   logic [DATA_W:0] shifted;
   logic [DATA_W+1:0] trial;
   logic fits;

   assign mag_a = opa[DATA_W-1] ? (DATA_W'(0) - opa) : opa;
   assign mag_b = opb[DATA_W-1] ? (DATA_W'(0) - opb) : opb;
   assign shifted = {rem_ff, quo_ff[DATA_W-1]};
   assign trial = {1'b0, shifted} - {2'b00, dvs_ff};
   assign fits = ~trial[DATA_W+1];

   always_comb begin
      state_in = state_ff;
      done_in = 1'b0;
      value_in = value_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      unique case (state_ff)
         A_IDLE: begin
            if (cmd.start) begin
               unique case (cmd.op)
                  ALU_ADD: begin
                     value_in = opa + opb;
                     done_in = 1'b1;
                  end
                  ALU_SUB: begin
                     value_in = opa - opb;
                     done_in = 1'b1;
                  end
                  ALU_MUL: begin
                     value_in = opa * opb;
                     done_in = 1'b1;
                  end
                  ALU_DIV: begin
                     quo_in = mag_a;
                     rem_in = '0;
                     dvs_in = mag_b;
                     neg_in = opa[DATA_W-1] ^ opb[DATA_W-1];
                     cnt_in = DIV_CNT_W'(DATA_W - 1);
                     state_in = A_DIV;
                  end
               endcase
            end
         end
         A_DIV: begin
            rem_in = fits ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], fits};
            cnt_in = cnt_ff - DIV_CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = A_FIX;
            end
         end
         A_FIX: begin
            // A negative quotient with a nonzero remainder rounds down one more step.
            if (!neg_ff) begin
               value_in = quo_ff;
            end else if (rem_ff != '0) begin
               value_in = ~quo_ff;
            end else begin
               value_in = DATA_W'(0) - quo_ff;
            end
            done_in = 1'b1;
            state_in = A_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
      value_ff <= value_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

   assign res.done = done_ff;
   assign res.value = value_ff;
endmodule

[sv/rpncalc_checker.sv]
// Port-level checker for the RPN stack calculator, bound to the top level.
// Depends on rpncalc_pkg and rpn_stack_calculator_core.
module rpncalc_checker #(
   parameter int STACK_DEPTH = rpncalc_pkg::STACK_DEPTH_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [rpncalc_pkg::DATA_W-1:0] rsp_result,
   input logic [rpncalc_pkg::STATUS_W-1:0] rsp_status,
   input logic [rpncalc_pkg::DEPTH_OUT_W-1:0] rsp_depth
);
   import rpncalc_pkg::*;

   // A stalled response word keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result) && $stable(rsp_status)
         && $stable(rsp_depth))
      else $error("response changed while stalled");

   // The block works on one word at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // Every error status comes with a zero result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_result == '0)
      else $error("nonzero result on error");

   // A full stack reports the full depth.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |-> rsp_depth == DEPTH_OUT_W'(STACK_DEPTH))
      else $error("full status at wrong depth");

   // Underflow statuses only occur on a nearly empty stack.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_EMPTY || rsp_status == STATUS_FEW)
         |-> rsp_depth < DEPTH_OUT_W'(2))
      else $error("underflow status with operands present");
endmodule

bind rpn_stack_calculator_core rpncalc_checker #(
   .STACK_DEPTH(STACK_DEPTH)
) u_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_port.valid),
   .req_ready(req_port.ready),
   .rsp_valid(rsp_port.valid),
   .rsp_ready(rsp_port.ready),
   .rsp_result(rsp_port.result),
   .rsp_status(rsp_port.status),
   .rsp_depth(rsp_port.depth)
);

[tb/tb_rpn_stack_calculator_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for rpn_stack_calculator_core: drives request words, predicts
// every response word from its own model of the stack and compares field by field.
// Depends on rpncalc_pkg, rpncalc_req_if, rpncalc_rsp_if and the core itself.
module tb_rpn_stack_calculator_core;
   import rpncalc_pkg::*;

   localparam int STACK_SIZE = STACK_DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 500000;
   localparam int RANDOM_WORDS = 170;

   typedef struct packed {
      logic [DATA_W-1:0] result;
      status_type status;
      logic [DEPTH_OUT_W-1:0] depth;
   } answer_type;

   class calc_scoreboard;
      logic [DATA_W-1:0] stack_mem [STACK_SIZE];
      int level;
      int errors;
      answer_type pending_answers[$];

      function new();
         level = 0;
         errors = 0;
      endfunction

      function logic [DATA_W-1:0] floor_quotient(logic [DATA_W-1:0] num,
                                                 logic [DATA_W-1:0] den);
         longint n;
         longint d;
         longint q;
         n = $signed(num);
         d = $signed(den);
         q = n / d;
         if ((n % d) != 0 && ((n < 0) != (d < 0))) begin
            q = q - 1;
         end
         return DATA_W'(q);
      endfunction

      function void note_word(kind_type kind, logic [DATA_W-1:0] value,
                              logic [INDEX_W-1:0] index);
         answer_type ans;
         logic [DATA_W-1:0] top;
         logic [DATA_W-1:0] second;
         ans.result = '0;
         ans.status = STATUS_OK;
         case (kind)
            KIND_PUSH: begin
               if (level >= STACK_SIZE) begin
                  ans.status = STATUS_FULL;
               end else begin
                  stack_mem[level] = value;
                  level++;
               end
            end
            KIND_POP: begin
               if (level == 0) begin
                  ans.status = STATUS_EMPTY;
               end else begin
                  level--;
                  ans.result = stack_mem[level];
               end
            end
            KIND_PEEK_TOP: begin
               if (int'(index) >= level) begin
                  ans.status = STATUS_RANGE;
               end else begin
                  ans.result = stack_mem[level - 1 - int'(index)];
               end
            end
            KIND_PEEK_BOTTOM: begin
               if (int'(index) >= level) begin
                  ans.status = STATUS_RANGE;
               end else begin
                  ans.result = stack_mem[int'(index)];
               end
            end
            default: begin
               if (level < 2) begin
                  ans.status = STATUS_FEW;
               end else begin
                  top = stack_mem[level - 1];
                  second = stack_mem[level - 2];
                  level -= 2;
                  case (kind)
                     KIND_ADD: ans.result = second + top;
                     KIND_SUB: ans.result = second - top;
                     KIND_MUL: ans.result = second * top;
                     default: begin
                        if (top == '0) begin
                           ans.status = STATUS_DIVZERO;
                        end else begin
                           ans.result = floor_quotient(second, top);
                        end
                     end
                  endcase
                  if (ans.status == STATUS_OK) begin
                     stack_mem[level] = ans.result;
                     level++;
                  end
               end
            end
         endcase
         ans.depth = DEPTH_OUT_W'(level);
         pending_answers.push_back(ans);
      endfunction

      task report(string msg);
         $display("Mismatch: %s", msg);
         errors++;
      endtask

      task check_result(logic [DATA_W-1:0] result, logic [STATUS_W-1:0] status,
                        logic [DEPTH_OUT_W-1:0] depth);
         answer_type want;
         if (pending_answers.size() == 0) begin
            report($sformatf("unexpected word result %h status %0d depth %0d",
                             result, status, depth));
            return;
         end
         want = pending_answers.pop_front();
         if (result !== want.result) begin
            report($sformatf("result %h, expected %h", result, want.result));
         end
         if (status !== want.status) begin
            report($sformatf("status %0d, expected %0d", status, want.status));
         end
         if (depth !== want.depth) begin
            report($sformatf("depth %0d, expected %0d", depth, want.depth));
         end
      endtask
   endclass

   logic clock;
   logic reset;
   int send_idle_pct;
   int stall_pct;
   int hold_cycles;
   int words_sent;
   int results_seen;
   int cycle_count;
   calc_scoreboard sb;

   rpncalc_req_if req_if ();
   rpncalc_rsp_if rsp_if ();

   rpn_stack_calculator_core dut (
      .clock(clock),
      .reset(reset),
      .req_port(req_if),
      .rsp_port(rsp_if)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) begin
         sb.note_word(kind_type'(req_if.kind), req_if.value, req_if.index);
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         sb.check_result(rsp_if.result, rsp_if.status, rsp_if.depth);
         results_seen++;
      end
   end

   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_if.ready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   task automatic send_word(kind_type kind, logic [DATA_W-1:0] value,
                            logic [INDEX_W-1:0] index);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.kind <= kind;
      req_if.value <= value;
      req_if.index <= index;
      do @(posedge clock); while (!req_if.ready);
      words_sent++;
   endtask

   task automatic wait_for_results();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (words_sent != results_seen);
   endtask

   function automatic logic [DATA_W-1:0] random_value();
      logic [DATA_W-1:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = $urandom_range(0, 16) - 8;
         4: begin
            case ($urandom_range(0, 4))
               0: v = '0;
               1: v = 32'd1;
               2: v = '1;
               3: v = 32'h7fff_ffff;
               default: v = 32'h8000_0000;
            endcase
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic run_random(int count);
      kind_type kind;
      logic [INDEX_W-1:0] index;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) < 4) begin
            kind = KIND_PUSH;
         end else begin
            kind = kind_type'($urandom_range(1, 7));
         end
         if (sb.level > 0 && sb.level < STACK_SIZE && $urandom_range(0, 3) != 0) begin
            index = INDEX_W'($urandom_range(0, sb.level));
         end else begin
            index = INDEX_W'($urandom_range(0, STACK_SIZE - 1));
         end
         if ($urandom_range(0, 63) == 0) begin
            wait_for_results();
         end
         send_word(kind, random_value(), index);
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.kind <= KIND_PUSH;
      req_if.value <= '0;
      req_if.index <= '0;
      send_idle_pct = 0;
      stall_pct = 0;
      hold_cycles = 0;
      words_sent = 0;
      results_seen = 0;
      cycle_count = 0;
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Empty-stack errors, wrapping arithmetic, divide overflow, divide by zero and floor rounding.
      send_word(KIND_POP, 32'd5, '0);
      send_word(KIND_PEEK_TOP, '0, '0);
      send_word(KIND_PEEK_BOTTOM, '0, '1);
      send_word(KIND_ADD, '0, '0);
      send_word(KIND_PUSH, 32'h7fff_ffff, '0);
      send_word(KIND_DIV, '0, '0);
      send_word(KIND_PUSH, 32'd1, '0);
      send_word(KIND_ADD, '0, '0);
      send_word(KIND_PUSH, '1, '0);
      send_word(KIND_DIV, '0, '0);
      send_word(KIND_PEEK_TOP, '0, '0);
      send_word(KIND_PEEK_BOTTOM, '0, 10'd1);
      send_word(KIND_PUSH, '0, '0);
      send_word(KIND_DIV, '0, '0);
      send_word(KIND_PUSH, 32'h8000_0000, '0);
      send_word(KIND_PUSH, 32'h8000_0000, '0);
      send_word(KIND_MUL, '0, '0);
      send_word(KIND_PUSH, -32'sd7, '0);
      send_word(KIND_PUSH, 32'd2, '0);
      send_word(KIND_DIV, '0, '0);
      send_word(KIND_PUSH, -32'sd6, '0);
      send_word(KIND_PUSH, 32'd3, '0);
      send_word(KIND_DIV, '0, '0);
      send_word(KIND_SUB, '0, '0);
      send_word(KIND_PEEK_BOTTOM, '0, '0);
      send_word(KIND_POP, '0, '0);
      send_word(KIND_POP, '0, '0);
      wait_for_results();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = 66;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 66;
            end
            default: begin
               send_idle_pct = 13;
               stall_pct = 13;
            end
         endcase
         if (phase == 0) begin
            run_random(60);
            hold_cycles = 250;
            run_random(RANDOM_WORDS - 60);
         end else if (phase == 3) begin
            // Fill the stack to the brim, push into a full stack, then peek at the far ends.
            while (sb.level < STACK_SIZE) begin
               send_word(KIND_PUSH, random_value(), '0);
            end
            send_word(KIND_PUSH, random_value(), '0);
            send_word(KIND_PUSH, random_value(), '0);
            send_word(KIND_PEEK_TOP, '0, '1);
            send_word(KIND_PEEK_BOTTOM, '0, '1);
            send_word(KIND_PEEK_BOTTOM, '0, 10'd512);
            run_random(RANDOM_WORDS);
         end else begin
            run_random(RANDOM_WORDS);
         end
         wait_for_results();
      end

      repeat (60) @(posedge clock);
      if (sb.errors == 0 && sb.pending_answers.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule

[filelist.f]
sv/rpncalc_pkg.sv
sv/rpncalc_req_if.sv
sv/rpncalc_rsp_if.sv
sv/rpncalc_ram.sv
sv/rpncalc_alu.sv
sv/rpn_stack_calculator_core.sv
sv/rpncalc_checker.sv
tb/tb_rpn_stack_calculator_core.sv
